/* rtl/assert_macros.svh */
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/whep_pkg.sv */
`default_nettype none

package whep_pkg;

  // Field widths of the report and of the limits.
  localparam int ATT_W = 12;
  localparam int STR_W = 8;
  localparam int BRK_W = 16;

  // Default number of reports in the window.
  localparam int WINDOW_DEPTH_DEF = 3;

  // Register port geometry.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Register reset values. Attempt limits are Q4.8 (1.2 and 1.02).
  localparam logic [ATT_W-1:0]        ATT_HI_RST  = 12'd307;
  localparam logic [ATT_W-1:0]        ATT_LO_RST  = 12'd261;
  localparam logic signed [STR_W-1:0] STR_HI_RST  = -8'sd55;
  localparam logic signed [STR_W-1:0] STR_LO_RST  = -8'sd63;
  localparam logic [BRK_W-1:0]        BRK_LIM_RST = 16'd1000;

  // Register indexes, taken from paddr[4:2].
  typedef enum logic [2:0] {
    REG_ATT_HI  = 3'd0,
    REG_ATT_LO  = 3'd1,
    REG_STR_HI  = 3'd2,
    REG_STR_LO  = 3'd3,
    REG_BRK_LIM = 3'd4,
    REG_MODE    = 3'd5
  } reg_idx_t;

  // Policy modes.
  localparam logic MODE_BASIC = 1'b0;
  localparam logic MODE_DUAL  = 1'b1;

  // Configuration as seen by the decision logic.
  typedef struct packed {
    logic [ATT_W-1:0]        attempt_hi;
    logic [ATT_W-1:0]        attempt_lo;
    logic signed [STR_W-1:0] strength_hi;
    logic signed [STR_W-1:0] strength_lo;
    logic [BRK_W-1:0]        broken_lim;
    logic                    mode;
  } cfg_t;

endpackage

`default_nettype wire

/* rtl/whep_if.sv */
`default_nettype none

// Report channel into the block.
interface whep_in_if;
  logic                     valid;
  logic                     ready;
  logic [11:0]              attempt_avg;
  logic signed [7:0]        strength_dbm;
  logic [15:0]              broken_count;

  modport source (output valid, attempt_avg, strength_dbm, broken_count, input ready);
  modport sink   (input valid, attempt_avg, strength_dbm, broken_count, output ready);
endinterface

// Result channel out of the block.
interface whep_out_if;
  logic valid;
  logic ready;
  logic enable_out;

  modport source (output valid, enable_out, input ready);
  modport sink   (input valid, enable_out, output ready);
endinterface

`default_nettype wire

/* rtl/whep_cfg.sv */
`default_nettype none

module whep_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [whep_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [whep_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [whep_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready,
  output whep_pkg::cfg_t                   cfg
);
  import whep_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // Register writes; unused indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attempt_hi  <= ATT_HI_RST;
      cfg_r.attempt_lo  <= ATT_LO_RST;
      cfg_r.strength_hi <= STR_HI_RST;
      cfg_r.strength_lo <= STR_LO_RST;
      cfg_r.broken_lim  <= BRK_LIM_RST;
      cfg_r.mode        <= MODE_BASIC;
    end else if (wr_en) begin
      unique case (idx)
        REG_ATT_HI:  cfg_r.attempt_hi  <= pwdata[ATT_W-1:0];
        REG_ATT_LO:  cfg_r.attempt_lo  <= pwdata[ATT_W-1:0];
        REG_STR_HI:  cfg_r.strength_hi <= pwdata[STR_W-1:0];
        REG_STR_LO:  cfg_r.strength_lo <= pwdata[STR_W-1:0];
        REG_BRK_LIM: cfg_r.broken_lim  <= pwdata[BRK_W-1:0];
        REG_MODE:    cfg_r.mode        <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read back, zero extended to the bus width.
  always_comb begin
    unique case (idx)
      REG_ATT_HI:  prdata = {{(CFG_DATA_W-ATT_W){1'b0}}, cfg_r.attempt_hi};
      REG_ATT_LO:  prdata = {{(CFG_DATA_W-ATT_W){1'b0}}, cfg_r.attempt_lo};
      REG_STR_HI:  prdata = {{(CFG_DATA_W-STR_W){1'b0}}, cfg_r.strength_hi};
      REG_STR_LO:  prdata = {{(CFG_DATA_W-STR_W){1'b0}}, cfg_r.strength_lo};
      REG_BRK_LIM: prdata = {{(CFG_DATA_W-BRK_W){1'b0}}, cfg_r.broken_lim};
      REG_MODE:    prdata = {{(CFG_DATA_W-1){1'b0}}, cfg_r.mode};
      default:     prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/whep_core.sv */
`default_nettype none

module whep_core #(
  parameter int WINDOW_DEPTH = whep_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               step,
  input  logic [whep_pkg::ATT_W-1:0]         attempt,
  input  logic signed [whep_pkg::STR_W-1:0]  strength,
  input  logic [whep_pkg::BRK_W-1:0]         broken,
  input  whep_pkg::cfg_t                     cfg,
  output logic                               enable_nxt
);
  import whep_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

  logic [ATT_W-1:0]        att_win_r   [WINDOW_DEPTH];
  logic [ATT_W-1:0]        att_win_nxt [WINDOW_DEPTH];
  logic signed [STR_W-1:0] str_win_r   [WINDOW_DEPTH];
  logic signed [STR_W-1:0] str_win_nxt [WINDOW_DEPTH];
  logic [CNT_W-1:0]        fill_cnt_r;
  logic                    enable_r;

  logic filled;
  logic att_all_ge_hi;
  logic att_all_le_lo;
  logic str_all_ge_hi;
  logic str_all_le_lo;
  logic broken_force;
  logic turn_off;

  // Window as it stands with the current report at the front.
  always_comb begin
    att_win_nxt[0] = attempt;
    str_win_nxt[0] = strength;
    for (int i = 1; i < WINDOW_DEPTH; i++) begin
      att_win_nxt[i] = att_win_r[i-1];
      str_win_nxt[i] = str_win_r[i-1];
    end
  end

  // Every sample against each limit, in parallel.
  always_comb begin
    att_all_ge_hi = 1'b1;
    att_all_le_lo = 1'b1;
    str_all_ge_hi = 1'b1;
    str_all_le_lo = 1'b1;
    for (int i = 0; i < WINDOW_DEPTH; i++) begin
      att_all_ge_hi &= (att_win_nxt[i] >= cfg.attempt_hi);
      att_all_le_lo &= (att_win_nxt[i] <= cfg.attempt_lo);
      str_all_ge_hi &= (str_win_nxt[i] >= cfg.strength_hi);
      str_all_le_lo &= (str_win_nxt[i] <= cfg.strength_lo);
    end
  end

  // The window counts as full once this report completes it.
  assign filled       = (fill_cnt_r >= CNT_W'(WINDOW_DEPTH - 1));
  assign broken_force = (cfg.mode == MODE_BASIC) && (broken > cfg.broken_lim);
  assign turn_off     = str_all_ge_hi && ((cfg.mode == MODE_BASIC) || att_all_le_lo);

  // Hysteresis decision; the broken override wins over the window.
  always_comb begin
    priority if (broken_force) begin
      enable_nxt = 1'b1;
    end else if (!filled) begin
      enable_nxt = enable_r;
    end else if (!enable_r) begin
      enable_nxt = att_all_ge_hi && str_all_le_lo;
    end else begin
      enable_nxt = !turn_off;
    end
  end

  // Window samples only matter once filled, so they carry no reset.
  always_ff @(posedge clk) begin
    if (step) begin
      att_win_r <= att_win_nxt;
      str_win_r <= str_win_nxt;
    end
  end

  // Fill count saturates at the depth; flag follows each report.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_cnt_r <= '0;
      enable_r   <= 1'b0;
    end else if (step) begin
      if (fill_cnt_r != CNT_W'(WINDOW_DEPTH)) begin
        fill_cnt_r <= fill_cnt_r + CNT_W'(1);
      end
      enable_r <= enable_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/windowed_hysteresis_enable_policy.sv */
// Each request passes through the input register and then the result register.
// Throughput: one request per cycle; a stalled result holds the input
// register, and the input stalls only while both registers are full and the
// result is held off.
// Reset (synchronous, rst_n low): registers return to their defaults, the
// window counts as empty, the enable flag clears and both stages empty.
`default_nettype none

module windowed_hysteresis_enable_policy #(
  parameter int WINDOW_DEPTH = whep_pkg::WINDOW_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  whep_in_if.sink                          in_chan,
  whep_out_if.source                       out_chan,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [whep_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [whep_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [whep_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import whep_pkg::*;

  cfg_t                    cfg;
  logic                    s1_valid_r;
  logic                    s1_valid_nxt;
  logic [ATT_W-1:0]        s1_attempt_r;
  logic signed [STR_W-1:0] s1_strength_r;
  logic [BRK_W-1:0]        s1_broken_r;
  logic                    out_valid_r;
  logic                    out_valid_nxt;
  logic                    out_enable_r;
  logic                    enable_nxt;
  logic                    in_fire;
  logic                    advance;

  whep_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  whep_core #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .attempt    (s1_attempt_r),
    .strength   (s1_strength_r),
    .broken     (s1_broken_r),
    .cfg        (cfg),
    .enable_nxt (enable_nxt)
  );

  // Handshake: the input stage moves on whenever the result register frees.
  assign advance        = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready  = !s1_valid_r || advance;
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign s1_valid_nxt   = in_fire || (s1_valid_r && !advance);
  assign out_valid_nxt  = advance || (out_valid_r && !out_chan.ready);

  assign out_chan.valid      = out_valid_r;
  assign out_chan.enable_out = out_enable_r;

  // Stage valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_attempt_r  <= in_chan.attempt_avg;
      s1_strength_r <= in_chan.strength_dbm;
      s1_broken_r   <= in_chan.broken_count;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (advance) begin
      out_enable_r <= enable_nxt;
    end
  end

endmodule

`default_nettype wire

/* rtl/whep_checker.sv */
`default_nettype none
`include "assert_macros.svh"

module whep_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_enable,
  input logic pready
);

  // The register port never inserts wait states.
  `ASSERT_CLK(a_pready_high, clk, rst_n, pready, "pready dropped")

  // A result waiting to be taken keeps its value.
  `ASSERT_CLK(a_out_hold, clk, rst_n,
              (out_valid && !out_ready) |=> (out_valid && $stable(out_enable)),
              "stalled result changed")

  // Reset empties the result register.
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result valid after reset")

  // The input only stalls when both stages are full and the output stalls.
  `ASSERT_CLK(a_backpressure, clk, rst_n,
              !in_ready |-> (out_valid && !out_ready),
              "input stalled without output stall")

endmodule

bind windowed_hysteresis_enable_policy whep_checker u_whep_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_enable (out_chan.enable_out),
  .pready     (pready)
);

`default_nettype wire

/* bench/windowed_hysteresis_enable_policy_tb.sv */
`timescale 1ns / 100ps

module windowed_hysteresis_enable_policy_tb;
  import whep_pkg::*;

  localparam int WIN_DEPTH = WINDOW_DEPTH_DEF;
  localparam int RESET_CYCLES = 4;
  localparam int LONG_HOLD = 200;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 104;
  localparam int DRAIN_CYCLES = 4;
  // Index past the end of the register list; writes there must be dropped.
  localparam logic [2:0] REG_UNUSED = 3'd6;

  typedef enum {ROW_REPORT, ROW_WRITE} row_kind_t;
  typedef enum {LEAN_ON, LEAN_OFF, LEAN_NOISE} lean_t;

  typedef struct {
    row_kind_t         kind;
    logic [2:0]        idx;
    logic [31:0]       data;
    logic [11:0]       att;
    logic signed [7:0] str;
    logic [15:0]       brk;
    bit                pinned;
    bit                pin_val;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel;
  logic penable;
  logic pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  whep_in_if  in_if ();
  whep_out_if out_if ();

  windowed_hysteresis_enable_policy dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #10 clk = ~clk;

  // Predictor state: limits, sample windows and the enable flag.
  cfg_t              lim = '{attempt_hi: ATT_HI_RST, attempt_lo: ATT_LO_RST,
                             strength_hi: STR_HI_RST, strength_lo: STR_LO_RST,
                             broken_lim: BRK_LIM_RST, mode: MODE_BASIC};
  logic [11:0]       att_win [WIN_DEPTH] = '{default: '0};
  logic signed [7:0] str_win [WIN_DEPTH] = '{default: '0};
  int                win_slot = 0;
  bit                win_full = 1'b0;
  bit                flag = 1'b0;

  bit enable_q [$];
  int fail_count = 0;
  bit quiet = 1'b0;
  bit hold_off_req = 1'b0;
  bit cur_pinned;
  bit cur_pin_val;
  stim_row_t steps [$];

  task automatic report_mismatch(string what);
    $display("ERROR at %0t: %s", $time, what);
    fail_count++;
  endtask

  // Enable flag after one report, updating the windows and the flag.
  function automatic bit next_enable(logic [11:0] att, logic signed [7:0] str,
                                     logic [15:0] brk);
    bit up_ok;
    bit down_ok;
    att_win[win_slot] = att;
    str_win[win_slot] = str;
    if (win_slot == WIN_DEPTH - 1) begin
      win_slot = 0;
      win_full = 1'b1;
    end else begin
      win_slot++;
    end
    if (lim.mode == MODE_BASIC && brk > lim.broken_lim) begin
      flag = 1'b1;
    end else if (win_full) begin
      up_ok = 1'b1;
      down_ok = 1'b1;
      for (int k = 0; k < WIN_DEPTH; k++) begin
        if (att_win[k] < lim.attempt_hi) up_ok = 1'b0;
        if (str_win[k] > $signed(lim.strength_lo)) up_ok = 1'b0;
        if (str_win[k] < $signed(lim.strength_hi)) down_ok = 1'b0;
        if (lim.mode == MODE_DUAL && att_win[k] > lim.attempt_lo) down_ok = 1'b0;
      end
      if (!flag && up_ok) flag = 1'b1;
      else if (flag && down_ok) flag = 1'b0;
    end
    return flag;
  endfunction

  // Result check first, then the new request's prediction is queued.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        if (enable_q.size() == 0) begin
          report_mismatch("result with no request pending");
        end else if (out_if.enable_out !== enable_q[0]) begin
          report_mismatch($sformatf("enable_out %b, expected %b",
                                    out_if.enable_out, enable_q[0]));
          void'(enable_q.pop_front());
        end else begin
          void'(enable_q.pop_front());
        end
      end
      if (in_if.valid && in_if.ready) begin
        if (cur_pinned) begin
          void'(next_enable(in_if.attempt_avg, in_if.strength_dbm, in_if.broken_count));
          enable_q.push_back(cur_pin_val);
        end else begin
          enable_q.push_back(next_enable(in_if.attempt_avg, in_if.strength_dbm,
                                         in_if.broken_count));
        end
      end
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin : result_ready
    int n;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_if.ready <= 1'b0;
        for (n = 0; n < LONG_HOLD; n++) @(negedge clk);
        out_if.ready <= 1'b1;
      end else if (!quiet && $urandom_range(7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(14, 1)) @(negedge clk);
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // Offer one request, with an occasional gap first, and wait for acceptance.
  task automatic send_report(logic [11:0] att, logic signed [7:0] str, logic [15:0] brk,
                             bit pinned, bit pin_val);
    @(negedge clk);
    if (!quiet && $urandom_range(5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(14, 1)) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.attempt_avg <= att;
    in_if.strength_dbm <= str;
    in_if.broken_count <= brk;
    cur_pinned <= pinned;
    cur_pin_val <= pin_val;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Stop offering, wait for every result, then let the pipeline settle.
  task automatic finish_burst();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (enable_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ATT_HI:  lim.attempt_hi = data[11:0];
      REG_ATT_LO:  lim.attempt_lo = data[11:0];
      REG_STR_HI:  lim.strength_hi = data[7:0];
      REG_STR_LO:  lim.strength_lo = data[7:0];
      REG_BRK_LIM: lim.broken_lim = data[15:0];
      REG_MODE:    lim.mode = data[0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic check_reg(reg_idx_t idx);
    logic [31:0] want;
    logic [31:0] mask;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ATT_HI:  begin want = {20'b0, lim.attempt_hi};  mask = 32'hFFF;  end
      REG_ATT_LO:  begin want = {20'b0, lim.attempt_lo};  mask = 32'hFFF;  end
      REG_STR_HI:  begin want = {24'b0, lim.strength_hi}; mask = 32'hFF;   end
      REG_STR_LO:  begin want = {24'b0, lim.strength_lo}; mask = 32'hFF;   end
      REG_BRK_LIM: begin want = {16'b0, lim.broken_lim};  mask = 32'hFFFF; end
      default:     begin want = {31'b0, lim.mode};        mask = 32'h1;    end
    endcase
    if ((prdata & mask) !== want)
      report_mismatch($sformatf("register %s reads %h, expected %h",
                                idx.name(), prdata & mask, want));
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_all_regs();
    for (int k = REG_ATT_HI; k <= REG_MODE; k++) check_reg(reg_idx_t'(k));
  endtask

  // Full register set, with random junk above each register's width.
  task automatic set_limits(logic [11:0] ah, logic [11:0] al, logic [7:0] sh,
                            logic [7:0] sl, logic [15:0] bl, logic md);
    cfg_write(REG_ATT_HI,  ($urandom << ATT_W) | {20'b0, ah});
    cfg_write(REG_ATT_LO,  ($urandom << ATT_W) | {20'b0, al});
    cfg_write(REG_STR_HI,  ($urandom << STR_W) | {24'b0, sh});
    cfg_write(REG_STR_LO,  ($urandom << STR_W) | {24'b0, sl});
    cfg_write(REG_BRK_LIM, ($urandom << BRK_W) | {16'b0, bl});
    cfg_write(REG_MODE,    ($urandom << 1) | {31'b0, md});
    check_all_regs();
  endtask

  function automatic int rand_between(int lo_v, int hi_v);
    return lo_v + int'($urandom_range(hi_v - lo_v, 0));
  endfunction

  // Report biased toward enabling, toward disabling, or plain noise.
  task automatic pick_report(lean_t lean, output logic [11:0] att,
                             output logic signed [7:0] str, output logic [15:0] brk);
    int r;
    att = 12'($urandom_range(4095));
    str = 8'($urandom_range(255));
    if (lean == LEAN_ON) begin
      if ($urandom_range(99) < 85) att = 12'(rand_between(lim.attempt_hi, 4095));
      if ($urandom_range(99) < 85)
        str = 8'(rand_between(-128, int'($signed(lim.strength_lo))));
    end else if (lean == LEAN_OFF) begin
      if (lim.mode == MODE_DUAL && $urandom_range(99) < 85)
        att = 12'(rand_between(0, lim.attempt_lo));
      if ($urandom_range(99) < 85)
        str = 8'(rand_between(int'($signed(lim.strength_hi)), 127));
    end
    // Exact limit values now and then.
    r = $urandom_range(19);
    if (r == 0) att = lim.attempt_hi;
    else if (r == 1) att = lim.attempt_lo;
    else if (r == 2) str = lim.strength_lo;
    else if (r == 3) str = lim.strength_hi;
    r = $urandom_range(99);
    if (r < 70) brk = 16'(rand_between(0, lim.broken_lim));
    else if (r < 80) brk = lim.broken_lim;
    else brk = 16'($urandom_range(65535));
  endtask

  function automatic void add_report(logic [11:0] att, logic signed [7:0] str,
                                     logic [15:0] brk, bit pinned = 1'b0,
                                     bit pin_val = 1'b0);
    stim_row_t row;
    row = '{kind: ROW_REPORT, idx: '0, data: '0, att: att, str: str, brk: brk,
            pinned: pinned, pin_val: pin_val};
    steps.push_back(row);
  endfunction

  function automatic void add_write(logic [2:0] idx, logic [31:0] data);
    stim_row_t row;
    row = '{kind: ROW_WRITE, idx: idx, data: data, att: '0, str: '0, brk: '0,
            pinned: 1'b0, pin_val: 1'b0};
    steps.push_back(row);
  endfunction

  initial begin : stimulus
    lean_t lean;
    int run_left;
    logic [11:0] att;
    logic signed [7:0] str;
    logic [15:0] brk;
    int r;

    in_if.valid = 1'b0;
    in_if.attempt_avg = '0;
    in_if.strength_dbm = '0;
    in_if.broken_count = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cur_pinned = 1'b0;
    cur_pin_val = 1'b0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    // Default limits: window not yet filled, then the broken override
    // before the window fills, and a count exactly at the limit.
    add_report(12'd0, 8'sd0, 16'd0, 1'b1, 1'b0);
    add_report(12'hFFF, -8'sd128, 16'hFFFF, 1'b1, 1'b1);
    add_report(12'hFFF, -8'sd128, BRK_LIM_RST);
    // Strong signal disables, weak signal with many retries enables.
    repeat (3) add_report(12'd0, 8'sd127, 16'd0);
    repeat (3) add_report(12'hFFF, -8'sd128, 16'd0);
    // The same at the exact limits.
    repeat (3) add_report(12'd0, STR_HI_RST, 16'd0);
    repeat (3) add_report(ATT_HI_RST, STR_LO_RST, 16'd0);
    // Wide value keeps only the low bits; mode switch keeps the window;
    // a write past the register list is dropped.
    add_write(REG_ATT_LO, 32'hABCD_E105);
    add_write(REG_MODE, 32'h8000_0003);
    add_write(REG_UNUSED, 32'hFFFF_FFFF);
    // Dual mode: broken count ignored, disable needs low attempts too.
    add_report(12'd0, 8'sd127, 16'hFFFF);
    repeat (2) add_report(ATT_LO_RST, 8'sd127, 16'hFFFF);
    repeat (3) add_report(12'hFFF, -8'sd128, 16'd0);
    repeat (3) add_report(12'hFFF, 8'sd127, 16'd0);

    foreach (steps[n]) begin
      if (steps[n].kind == ROW_WRITE) begin
        finish_burst();
        cfg_write(steps[n].idx, steps[n].data);
      end else begin
        send_report(steps[n].att, steps[n].str, steps[n].brk,
                    steps[n].pinned, steps[n].pin_val);
      end
    end
    finish_burst();
    check_all_regs();

    // Random phases, each under its own set of limits.
    for (int ph = 0; ph < PHASES; ph++) begin
      finish_burst();
      case (ph)
        0: set_limits(ATT_HI_RST, ATT_LO_RST, STR_HI_RST, STR_LO_RST, BRK_LIM_RST,
                      MODE_BASIC);
        1: set_limits(12'd0, 12'hFFF, 8'h80, 8'h7F, 16'd0, MODE_BASIC);
        2: set_limits(12'd0, 12'hFFF, 8'h80, 8'h7F, 16'd0, MODE_DUAL);
        3: set_limits(12'hFFF, 12'd0, 8'h7F, 8'h80, 16'hFFFF, MODE_BASIC);
        4: set_limits(12'hFFF, 12'd0, 8'h7F, 8'h80, 16'hFFFF, MODE_DUAL);
        default: set_limits(12'($urandom_range(4095)), 12'($urandom_range(4095)),
                            8'($urandom_range(255)), 8'($urandom_range(255)),
                            16'($urandom_range(2000)), 1'($urandom_range(1)));
      endcase
      quiet = (ph == PHASES - 1);
      if (ph == 1) hold_off_req = 1'b1;
      run_left = 0;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (run_left == 0) begin
          r = $urandom_range(9);
          lean = (r < 4) ? LEAN_ON : (r < 8) ? LEAN_OFF : LEAN_NOISE;
          run_left = $urandom_range(8, 3);
        end
        run_left--;
        pick_report(lean, att, str, brk);
        send_report(att, str, brk, 1'b0, 1'b0);
      end
    end
    finish_burst();

    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Hard limit on the run.
  initial begin : watchdog
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/whep_pkg.sv
rtl/whep_if.sv
rtl/whep_cfg.sv
rtl/whep_core.sv
rtl/windowed_hysteresis_enable_policy.sv
rtl/whep_checker.sv
bench/windowed_hysteresis_enable_policy_tb.sv
